@@ src/mms_pkg.sv @@
// Shared types, constants and helpers for the 16-to-8 bit min/max contrast stretch.
// No dependencies; imported by mms_req_if, mms_rsp_if, the divider and top level.
package mms_pkg;

   localparam int PIX_W = 16;
   localparam int OUT_W = 8;

   localparam logic [PIX_W-1:0] MIN_RESET  = '1;
   localparam logic [PIX_W-1:0] MAX_RESET  = '0;
   localparam logic [OUT_W-1:0] FULL_SCALE = '1;
   localparam logic [OUT_W-1:0] ZERO_PIX   = '0;

   localparam logic REQ_MEASURE = 1'b0;
   localparam logic REQ_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCALE,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [PIX_W-1:0] delta;
      logic [PIX_W-1:0] span;
   } div_ctl_type;

   typedef struct packed {
      logic             done;
      logic [OUT_W-1:0] quotient;
   } div_sts_type;

   function automatic logic [PIX_W-1:0] assemble(input logic big_endian,
                                                 input logic [7:0] first_byte,
                                                 input logic [7:0] second_byte);
      logic [PIX_W-1:0] pix;
      begin
         pix = big_endian ? {first_byte, second_byte} : {second_byte, first_byte};
         return pix;
      end
   endfunction

endpackage

@@ src/mms_if.sv @@
// Valid/ready channel interfaces: request, response and control register write.
// Depends on mms_pkg for widths.
interface mms_req_if;
   import mms_pkg::*;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] first_byte;
   logic [7:0] second_byte;
   logic       last_in_pass;

   modport source (output valid, req_type, first_byte, second_byte, last_in_pass,
                   input ready);
   modport sink (input valid, req_type, first_byte, second_byte, last_in_pass,
                 output ready);
endinterface

interface mms_rsp_if;
   import mms_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] stretched_pixel;

   modport source (output valid, stretched_pixel, input ready);
   modport sink (input valid, stretched_pixel, output ready);
endinterface

interface mms_csr_if;
   logic valid;
   logic ready;
   logic big_endian;

   modport source (output valid, big_endian, input ready);
   modport sink (input valid, big_endian, output ready);
endinterface

@@ src/mms_div.sv @@
// Restoring divider: (delta * 255) / span, one quotient bit per cycle, eight steps.
// Depends on mms_pkg; caller guarantees delta < span so the quotient fits 8 bits.
module mms_div (
   input  logic                 clock,
   input  logic                 reset,
   input  mms_pkg::div_ctl_type ctl,
   output mms_pkg::div_sts_type sts
);
   import mms_pkg::*;

   localparam int REM_W = PIX_W + OUT_W;
   localparam int DSR_W = PIX_W + OUT_W - 1;
   localparam int CNT_W = $clog2(OUT_W);

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DSR_W-1:0] dsr_ff, dsr_in;
   logic [OUT_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W:0]   diff;
   logic             fits;

   // one shared compare/subtract against the shifted divisor
   assign diff = {1'b0, rem_ff} - {2'b00, dsr_ff};
   assign fits = ~diff[REM_W];

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         // delta * 255 = (delta << 8) - delta
         rem_in  = {ctl.delta, {OUT_W{1'b0}}} - {{OUT_W{1'b0}}, ctl.delta};
         dsr_in  = {ctl.span, {(OUT_W-1){1'b0}}};
         cnt_in  = '1;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[REM_W-1:0] : rem_ff;
         dsr_in = dsr_ff >> 1;
         quo_in = {quo_ff[OUT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done     = done_ff;
   assign sts.quotient = quo_ff;

endmodule

@@ src/min_max_stretch_16_to_8_top.sv @@
// Min/max contrast stretch of 16-bit pixels to 8 bits. A measure request leaves the
// block idle and only updates the running minimum and maximum; it gives no response.
// A convert request gives one response, floor((pixel-min)*255/(max-min)), with 0 for
// an empty or zero range or a pixel at or below min, and 255 at or above max. A convert
// request occupies the block until its result is in the output register; saturated
// cases skip the eight-step restoring divider. A finished response sits in an output
// register, so the next request is taken while it waits. The last convert request of a
// pass returns min and max to their reset values. Byte order is set by big_endian.
module min_max_stretch_16_to_8_top (
   input logic   clock,
   input logic   reset,
   mms_req_if.sink   req_ch,
   mms_rsp_if.source rsp_ch,
   mms_csr_if.sink   csr_ch
);
   import mms_pkg::*;

   state_type        state_ff, state_in;
   logic             big_endian_ff;
   logic [PIX_W-1:0] min_ff, min_in;
   logic [PIX_W-1:0] max_ff, max_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic             last_ff, last_in;
   logic [OUT_W-1:0] res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0] rsp_pix_ff, rsp_pix_in;
   logic [PIX_W-1:0] req_pix;
   logic             req_fire;
   div_ctl_type      div_ctl;
   div_sts_type      div_sts;

   assign req_pix  = assemble(big_endian_ff, req_ch.first_byte, req_ch.second_byte);
   assign req_fire = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      pix_in       = pix_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      div_ctl.start = 1'b0;
      div_ctl.delta = pix_ff - min_ff;
      div_ctl.span  = max_ff - min_ff;
      req_ch.ready  = (state_ff == ST_IDLE);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.req_type == REQ_CONVERT) begin
                  pix_in   = req_pix;
                  last_in  = req_ch.last_in_pass;
                  state_in = ST_SCALE;
               end else begin
                  if (req_pix < min_ff) min_in = req_pix;
                  if (req_pix > max_ff) max_in = req_pix;
               end
            end
         end
         ST_SCALE: begin
            // min/max are consumed here, so the end-of-pass reset can happen now
            if (last_ff) begin
               min_in = MIN_RESET;
               max_in = MAX_RESET;
            end
            priority if (max_ff <= min_ff || pix_ff <= min_ff) begin
               res_in   = ZERO_PIX;
               state_in = ST_DONE;
            end else if (pix_ff >= max_ff) begin
               res_in   = FULL_SCALE;
               state_in = ST_DONE;
            end else begin
               div_ctl.start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_sts.done) begin
               res_in   = div_sts.quotient;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_pix_in   = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pix_ff     <= pix_in;
      last_ff    <= last_in;
      res_ff     <= res_in;
      rsp_pix_ff <= rsp_pix_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         big_endian_ff <= 1'b0;
         min_ff        <= MIN_RESET;
         max_ff        <= MAX_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            big_endian_ff <= csr_ch.big_endian;
         end
      end
   end

   mms_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   assign csr_ch.ready           = 1'b1;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.stretched_pixel = rsp_pix_ff;

endmodule

@@ src/mms_chk.sv @@
// Port-level checker for the contrast stretch top level, attached by bind.
// Depends on mms_pkg for widths and request codes.
module mms_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      req_type,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [mms_pkg::OUT_W-1:0] stretched_pixel
);
   import mms_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // a stalled response holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(stretched_pixel))
      else $error("response changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a convert request occupies the block
   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_CONVERT |=> !req_ready)
      else $error("request taken while a convert is in flight");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_MEASURE && !rsp_valid |=> !rsp_valid)
      else $error("measure request produced a response");

   assert property (@(posedge clock) disable iff (reset)
      req_fire && req_type == REQ_CONVERT && !rsp_valid |=> !rsp_valid ##1 !rsp_valid)
      else $error("convert response appeared too early");

endmodule

bind min_max_stretch_16_to_8_top mms_chk u_mms_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_type        (req_ch.req_type),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .stretched_pixel (rsp_ch.stretched_pixel)
);

@@ test/tb.sv @@
// Self-checking bench for the 16-to-8 bit min/max contrast stretch top level.
// Needs mms_pkg, the mms_*_if channel interfaces and min_max_stretch_16_to_8_top.
// Drives measure and convert requests, predicts each stretched pixel and checks every response.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mms_pkg::*;

   localparam int RESET_CYCLES = 12;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 300;
   localparam int RANDOM_ITEMS = 350;
   localparam int IDLE_PCT     = 15;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock = 1'b0;
   logic reset;

   mms_req_if req_ch ();
   mms_rsp_if rsp_ch ();
   mms_csr_if csr_ch ();

   min_max_stretch_16_to_8_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // predicted block state
   logic             cur_big_endian;
   logic [PIX_W-1:0] lo_seen;
   logic [PIX_W-1:0] hi_seen;
   logic [OUT_W-1:0] expected_pixels[$];

   int   error_count   = 0;
   int   cycle_count   = 0;
   int   sent_count    = 0;
   int   convert_count = 0;
   int   checked_count = 0;
   int   order_writes  = 0;
   logic no_idle       = 1'b0;
   logic rsp_hold      = 1'b0;
   event hold_go;

   task automatic report_error(input string what);
      $display("ERROR cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic [OUT_W-1:0] stretch_value(input logic [PIX_W-1:0] pix);
      logic [23:0]      scaled;
      logic [PIX_W-1:0] span;
      logic [23:0]      quot;
      if (hi_seen <= lo_seen) return ZERO_PIX;
      if (pix <= lo_seen) return ZERO_PIX;
      if (pix >= hi_seen) return FULL_SCALE;
      span   = hi_seen - lo_seen;
      scaled = 24'(pix - lo_seen) * 24'd255;
      quot   = scaled / 24'(span);
      return quot[OUT_W-1:0];
   endfunction

   // update predicted state for one accepted request
   task automatic predict_request(input logic kind, input logic [7:0] fb,
                                  input logic [7:0] sb, input logic last);
      logic [PIX_W-1:0] pix;
      pix = cur_big_endian ? {fb, sb} : {sb, fb};
      if (kind == REQ_MEASURE) begin
         if (pix < lo_seen) lo_seen = pix;
         if (pix > hi_seen) hi_seen = pix;
      end else begin
         expected_pixels.push_back(stretch_value(pix));
         convert_count++;
         if (last) begin
            lo_seen = MIN_RESET;
            hi_seen = MAX_RESET;
         end
      end
   endtask

   task automatic send_pixel(input logic kind, input logic [7:0] fb,
                             input logic [7:0] sb, input logic last);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.req_type     <= kind;
      req_ch.first_byte   <= fb;
      req_ch.second_byte  <= sb;
      req_ch.last_in_pass <= last;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(kind, fb, sb, last);
      sent_count++;
   endtask

   // split a pixel into stored bytes for the current byte order
   task automatic send_value(input logic kind, input logic [PIX_W-1:0] pix, input logic last);
      if (cur_big_endian) send_pixel(kind, pix[15:8], pix[7:0], last);
      else send_pixel(kind, pix[7:0], pix[15:8], last);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_byte_order(input logic be);
      wait_idle();
      csr_ch.valid      <= 1'b1;
      csr_ch.big_endian <= be;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      cur_big_endian = be;
      order_writes++;
   endtask

   // one well-formed image: measure pass, then convert pass, both closed by last
   task automatic random_image();
      int               n_meas;
      int               n_conv;
      int               spread;
      int               span;
      logic [PIX_W-1:0] base;
      logic [PIX_W-1:0] pix;
      n_meas = $urandom_range(1, 6);
      n_conv = $urandom_range(1, 6);
      base   = PIX_W'($urandom);
      case ($urandom_range(3))
         0: spread = 0;
         1: spread = $urandom_range(1, 15);
         2: spread = $urandom_range(16, 4095);
         default: spread = 65535;
      endcase
      for (int i = 0; i < n_meas; i++) begin
         pix = base + PIX_W'($urandom_range(spread));
         send_value(REQ_MEASURE, pix, i == n_meas - 1);
      end
      for (int i = 0; i < n_conv; i++) begin
         if ($urandom_range(99) < 20) begin
            pix = PIX_W'($urandom);
         end else begin
            span = int'(hi_seen) - int'(lo_seen);
            if (span < 0) span = 0;
            pix  = lo_seen - 16'd2 + PIX_W'($urandom_range(span + 4));
         end
         send_value(REQ_CONVERT, pix, i == n_conv - 1);
      end
   endtask

   // stray requests: converts with no measure, missing last flags, odd order
   task automatic noise_items();
      repeat ($urandom_range(1, 4))
         send_pixel(logic'($urandom_range(1)), 8'($urandom), 8'($urandom),
                    logic'($urandom_range(1)));
   endtask

   task automatic test_directed_cases();
      send_pixel(REQ_CONVERT, 8'h34, 8'h12, 1'b0);   // no measure yet: empty range
      send_pixel(REQ_MEASURE, 8'h00, 8'h00, 1'b0);
      send_pixel(REQ_MEASURE, 8'hFF, 8'hFF, 1'b1);   // last on a measure pixel
      send_pixel(REQ_CONVERT, 8'h00, 8'h00, 1'b0);
      send_pixel(REQ_CONVERT, 8'hFF, 8'hFF, 1'b0);
      send_pixel(REQ_CONVERT, 8'hFF, 8'h00, 1'b0);
      send_pixel(REQ_CONVERT, 8'h00, 8'hFF, 1'b0);
      send_pixel(REQ_CONVERT, 8'h80, 8'h80, 1'b1);   // result first, then min/max reset
      send_pixel(REQ_MEASURE, 8'h34, 8'h12, 1'b0);   // zero range image
      send_pixel(REQ_MEASURE, 8'h34, 8'h12, 1'b1);
      send_pixel(REQ_CONVERT, 8'h34, 8'h12, 1'b0);
      send_pixel(REQ_CONVERT, 8'h00, 8'h20, 1'b1);
      send_pixel(REQ_MEASURE, 8'h00, 8'h10, 1'b0);
      send_pixel(REQ_MEASURE, 8'h00, 8'h20, 1'b1);
      send_pixel(REQ_CONVERT, 8'h00, 8'h08, 1'b0);   // below min
      send_pixel(REQ_CONVERT, 8'h00, 8'h30, 1'b0);   // above max
      send_pixel(REQ_CONVERT, 8'h00, 8'h18, 1'b0);
      send_pixel(REQ_CONVERT, 8'h00, 8'h10, 1'b0);
      send_pixel(REQ_CONVERT, 8'h00, 8'h20, 1'b1);
      wait_idle();
   endtask

   task automatic test_byte_order();
      write_byte_order(1'b1);
      send_pixel(REQ_MEASURE, 8'h00, 8'h01, 1'b0);
      send_pixel(REQ_MEASURE, 8'hFF, 8'hFE, 1'b1);
      send_pixel(REQ_CONVERT, 8'hFF, 8'h00, 1'b0);
      send_pixel(REQ_CONVERT, 8'h00, 8'hFF, 1'b1);
      write_byte_order(1'b0);
      send_pixel(REQ_MEASURE, 8'h01, 8'h00, 1'b1);
      send_pixel(REQ_CONVERT, 8'hFF, 8'h00, 1'b1);
      wait_idle();
   endtask

   // receiver held off while converts keep coming, so the block backs up
   task automatic test_output_stall();
      send_value(REQ_MEASURE, 16'h0100, 1'b0);
      send_value(REQ_MEASURE, 16'hF000, 1'b1);
      -> hold_go;
      for (int i = 0; i < 16; i++)
         send_value(REQ_CONVERT, PIX_W'($urandom), i == 15);
      wait_idle();
   endtask

   task automatic test_back_to_back();
      no_idle <= 1'b1;
      repeat (8) random_image();
      wait_idle();
      no_idle <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random_images();
      int target;
      target = sent_count + RANDOM_ITEMS;
      while (sent_count < target) begin
         if ($urandom_range(99) < 12) noise_items();
         else random_image();
         if ($urandom_range(99) < 15) write_byte_order(~cur_big_endian);
      end
      wait_idle();
   endtask

   // response side: check, then pick ready for the next cycle
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_pixels.size() == 0) begin
               report_error($sformatf("response %0d with no request pending",
                                      rsp_ch.stretched_pixel));
            end else begin
               if (rsp_ch.stretched_pixel !== expected_pixels[0])
                  report_error($sformatf("stretched_pixel got %0d expected %0d",
                                         rsp_ch.stretched_pixel, expected_pixels[0]));
               void'(expected_pixels.pop_front());
               checked_count++;
            end
         end
         if (rsp_hold) rsp_ch.ready <= 1'b0;
         else if (no_idle) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always begin
      @(hold_go);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, expected_pixels.size());
      $display("status: fail");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.req_type     = REQ_MEASURE;
      req_ch.first_byte   = '0;
      req_ch.second_byte  = '0;
      req_ch.last_in_pass = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.big_endian   = 1'b0;
      cur_big_endian      = 1'b0;
      lo_seen             = MIN_RESET;
      hi_seen             = MAX_RESET;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      test_byte_order();
      test_output_stall();
      test_back_to_back();
      test_random_images();

      wait_idle();
      $display("summary: %0d requests (%0d converts), %0d responses checked, %0d errors",
               sent_count, convert_count, checked_count, error_count);
      $display("summary: %0d byte order writes, one %0d-cycle output hold, %0d cycles",
               order_writes, HOLD_CYCLES, cycle_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/mms_pkg.sv
src/mms_if.sv
src/mms_div.sv
src/min_max_stretch_16_to_8_top.sv
src/mms_chk.sv
test/tb.sv
